[sv/rsscc_pkg.sv]
// Shared types, codes and sizes for the RRT steer / sphere collision core.
// No dependencies; every other file of the block imports this package.
package rsscc_pkg;

    // Obstacle table size and derived widths
    localparam int MAX_OBSTACLES = 16;
    localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);
    localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;

    // Iterative divider: 51-bit dividend, 34-bit divisor, 17 quotient bits
    localparam int DIV_NUM_W = 51;
    localparam int DIV_DEN_W = 34;
    localparam int DIV_QUO_W = 17;

    // Iterative square root: 34-bit radicand, 17-bit root
    localparam int SQ_IN_W   = 34;
    localparam int SQ_ROOT_W = 17;

    // Projection value for t = 1.0 in Q1.16
    localparam logic [16:0] T_ONE = 17'h1_0000;

    // Configuration register indexes and reset values
    localparam logic [7:0]  CFG_MAX_STEP = 8'd0;
    localparam logic [7:0]  CFG_MIN_STEP = 8'd1;
    localparam logic [14:0] MAX_STEP_RST = 15'd410;
    localparam logic [14:0] MIN_STEP_RST = 15'd1;

    typedef enum logic {
        OP_STORE = 1'b0,
        OP_CHECK = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_FREE   = 3'd0,
        ST_CLOSE  = 3'd1,
        ST_HIT    = 3'd2,
        ST_STORED = 3'd3,
        ST_FULL   = 3'd4
    } status_t;

    // One queued request
    typedef struct packed {
        op_t                op;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic [14:0]        radius;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } item_t;

    // One obstacle table entry (63 bits)
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [14:0]        r;
    } sphere_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_QUO_W-1:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic               start;
        logic [SQ_IN_W-1:0] val;
    } sqrt_req_t;

    typedef struct packed {
        logic                 done;
        logic [SQ_ROOT_W-1:0] root;
        logic                 rem_nz;
    } sqrt_rsp_t;

    // Back-end sequencer states
    typedef enum logic [4:0] {
        BS_IDLE,
        BS_D2,
        BS_SQGO,
        BS_SQRT,
        BS_SMUL,
        BS_SGO,
        BS_SDIV,
        BS_LEN,
        BS_LCHK,
        BS_ORD,
        BS_OC,
        BS_PDOT,
        BS_PCHK,
        BS_PDIV,
        BS_QMUL,
        BS_EDOT,
        BS_ECHK,
        BS_RESULT
    } bstate_t;

endpackage

[sv/rsscc_front.sv]
// Front end: takes requests from the input channel, tags the operation and
// buffers them in a two-entry queue for the back end. Uses rsscc_pkg.
module rsscc_front
    import rsscc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_y,
    input  logic signed [15:0] point_z,
    input  logic [14:0]        radius,
    input  logic signed [15:0] near_x,
    input  logic signed [15:0] near_y,
    input  logic signed [15:0] near_z,
    output logic               q_valid,
    output item_t              q_item,
    input  logic               q_pop
);

    localparam int QDEPTH = 2;

    item_t       q_mem_reg [QDEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  q_cnt_reg, q_cnt_next;
    item_t       in_item;
    logic        push;
    logic        pop;

    // Classify and pack the incoming request
    always_comb
    begin
        in_item.op     = op_t'(operation);
        in_item.px     = point_x;
        in_item.py     = point_y;
        in_item.pz     = point_z;
        in_item.radius = radius;
        in_item.nx     = near_x;
        in_item.ny     = near_y;
        in_item.nz     = near_z;
    end

    assign in_ready = (q_cnt_reg != 2'(QDEPTH));
    assign q_valid  = (q_cnt_reg != 2'd0);
    assign q_item   = q_mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    // Queue pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        q_cnt_next  = q_cnt_reg;
        if (push && !pop)
        begin
            q_cnt_next = q_cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            q_cnt_next = q_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            q_cnt_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[sv/rsscc_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the steering and
// projection steps. Uses rsscc_pkg for widths and request/response structs.
module rsscc_div
    import rsscc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] dsh_reg, dsh_next;
    logic [DIV_QUO_W-1:0] quo_reg, quo_next;
    logic [DIV_NUM_W:0]   trial;

    assign trial = {1'b0, rem_reg} - {1'b0, dsh_reg};

    // One trial subtraction per cycle, divisor shifted down each step
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'(DIV_QUO_W - 1);
            rem_next  = req.num;
            dsh_next  = DIV_NUM_W'(req.den) << (DIV_QUO_W - 1);
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_NUM_W])
            begin
                rem_next = trial[DIV_NUM_W-1:0];
                quo_next = {quo_reg[DIV_QUO_W-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[DIV_QUO_W-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

[sv/rsscc_sqrt.sv]
// Integer square root, two radicand bits per cycle, with a flag for a
// nonzero remainder. Uses rsscc_pkg for widths and structs.
module rsscc_sqrt
    import rsscc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [SQ_IN_W-1:0]  v_reg, v_next;
    logic [SQ_IN_W:0]    res_reg, res_next;
    logic [SQ_IN_W-1:0]  bit_reg, bit_next;
    logic [SQ_IN_W:0]    sum;
    logic                ge;

    assign sum = res_reg + (SQ_IN_W + 1)'(bit_reg);
    assign ge  = ((SQ_IN_W + 1)'(v_reg) >= sum);

    // Digit-by-digit root: subtract (res + bit) when it fits
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            v_next    = req.val;
            res_next  = '0;
            bit_next  = SQ_IN_W'(1) << (2 * (SQ_ROOT_W - 1));
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                v_next   = SQ_IN_W'((SQ_IN_W + 1)'(v_reg) - sum);
                res_next = (res_reg >> 1) + (SQ_IN_W + 1)'(bit_reg);
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.root   = res_reg[SQ_ROOT_W-1:0];
    assign rsp.rem_nz = |v_reg;

endmodule

[sv/rsscc_back.sv]
// Back end: obstacle table, sequencer with one shared 18x18 multiplier,
// steering, per-obstacle segment test and the output register.
// Uses rsscc_pkg; drives rsscc_div and rsscc_sqrt through their structs.
module rsscc_back
    import rsscc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [14:0]        step_limit,
    input  logic [14:0]        step_floor,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               q_pop,
    output div_req_t           div_req,
    input  div_rsp_t           div_rsp,
    output sqrt_req_t          sq_req,
    input  sqrt_rsp_t          sq_rsp,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic signed [15:0] new_x,
    output logic signed [15:0] new_y,
    output logic signed [15:0] new_z
);

    localparam logic [2:0] K_LAST = 3'd4;
    localparam int         AXES   = 3;

    bstate_t               state_reg, state_next;
    logic [2:0]            k_reg, k_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic signed [15:0]    n_reg [AXES];
    logic signed [15:0]    n_next [AXES];
    logic signed [17:0]    s_reg [AXES];
    logic signed [17:0]    s_next [AXES];
    logic signed [16:0]    c_reg [AXES];
    logic signed [16:0]    c_next [AXES];
    logic signed [17:0]    e_reg [AXES];
    logic signed [17:0]    e_next [AXES];
    logic [14:0]           r_reg, r_next;
    logic [16:0]           dist_reg, dist_next;
    logic [33:0]           len_reg, len_next;
    logic [16:0]           t_reg, t_next;
    logic signed [37:0]    acc_reg, acc_next;
    logic signed [35:0]    prod_reg, prod_next;
    status_t               res_reg, res_next;
    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic signed [15:0]    out_x_reg, out_x_next;
    logic signed [15:0]    out_y_reg, out_y_next;
    logic signed [15:0]    out_z_reg, out_z_next;

    sphere_t               tbl_mem [MAX_OBSTACLES];
    sphere_t               rdata_reg;
    logic                  tbl_we;
    sphere_t               tbl_wdata;

    logic signed [17:0]    mul_a, mul_b;
    logic signed [35:0]    mul_p;
    logic signed [17:0]    sk, ek;
    logic signed [16:0]    ck;
    logic [35:0]           prod_mag;
    logic [18:0]           qmag;
    logic signed [18:0]    qrnd;
    logic                  too_close, need_steer;
    logic                  proj_zero, proj_full;
    logic                  last_obst, out_free, is_dot;

    assign mul_p = mul_a * mul_b;

    // Per-axis operands for the current step
    always_comb
    begin
        sk = '0;
        ck = '0;
        ek = '0;
        for (int j = 0; j < AXES; j++)
        begin
            if (k_reg == 3'(j))
            begin
                sk = s_reg[j];
                ck = c_reg[j];
                ek = e_reg[j];
            end
        end
    end

    // Decision terms
    assign too_close  = (sq_rsp.root < 17'(step_floor));
    assign need_steer = (sq_rsp.root > 17'(step_limit)) ||
                        ((sq_rsp.root == 17'(step_limit)) && sq_rsp.rem_nz);
    assign proj_zero  = (acc_reg <= 38'sd0) || (len_reg == 34'd0);
    assign proj_full  = (acc_reg >= $signed({4'b0, len_reg}));
    assign last_obst  = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);
    assign out_free   = !out_valid_reg || out_ready;
    assign is_dot     = (state_reg == BS_D2) || (state_reg == BS_LEN) ||
                        (state_reg == BS_PDOT) || (state_reg == BS_EDOT);

    // Rounded product / 65536, ties away from zero
    assign prod_mag = prod_reg[35] ? 36'(-prod_reg) : 36'(prod_reg);
    assign qmag     = 19'((prod_mag + 36'd32768) >> 16);
    assign qrnd     = prod_reg[35] ? -$signed(qmag) : $signed(qmag);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_item.op == OP_STORE) ? BS_RESULT : BS_D2;
                end
            end
            BS_D2:   if (k_reg == K_LAST) state_next = BS_SQGO;
            BS_SQGO: state_next = BS_SQRT;
            BS_SQRT:
            begin
                if (sq_rsp.done)
                begin
                    if (too_close)
                        state_next = BS_RESULT;
                    else if (need_steer)
                        state_next = BS_SMUL;
                    else
                        state_next = BS_LEN;
                end
            end
            BS_SMUL: state_next = BS_SGO;
            BS_SGO:  state_next = BS_SDIV;
            BS_SDIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = (k_reg == 3'(AXES - 1)) ? BS_LEN : BS_SMUL;
                end
            end
            BS_LEN:  if (k_reg == K_LAST) state_next = BS_LCHK;
            BS_LCHK: state_next = (cnt_reg == '0) ? BS_RESULT : BS_ORD;
            BS_ORD:  state_next = BS_OC;
            BS_OC:   state_next = BS_PDOT;
            BS_PDOT: if (k_reg == K_LAST) state_next = BS_PCHK;
            BS_PCHK: state_next = (proj_zero || proj_full) ? BS_QMUL : BS_PDIV;
            BS_PDIV: if (div_rsp.done) state_next = BS_QMUL;
            BS_QMUL: if (k_reg == 3'(AXES)) state_next = BS_EDOT;
            BS_EDOT: if (k_reg == K_LAST) state_next = BS_ECHK;
            BS_ECHK:
            begin
                if ((acc_reg <= 38'sd0) || last_obst)
                    state_next = BS_RESULT;
                else
                    state_next = BS_ORD;
            end
            BS_RESULT: if (out_free) state_next = BS_IDLE;
            default: state_next = BS_IDLE;
        endcase
    end

    // Datapath and handshake outputs
    always_comb
    begin
        k_next          = k_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        n_next          = n_reg;
        s_next          = s_reg;
        c_next          = c_reg;
        e_next          = e_reg;
        r_next          = r_reg;
        dist_next       = dist_reg;
        len_next        = len_reg;
        t_next          = t_reg;
        acc_next        = acc_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_z_next      = out_z_reg;
        q_pop           = 1'b0;
        tbl_we          = 1'b0;
        tbl_wdata.x     = q_item.px;
        tbl_wdata.y     = q_item.py;
        tbl_wdata.z     = q_item.pz;
        tbl_wdata.r     = q_item.radius;
        div_req         = '0;
        sq_req          = '0;
        mul_a           = '0;
        mul_b           = '0;

        // Shared dot-product loop: three products, one extra slot, one flush
        if (is_dot)
        begin
            acc_next = (k_reg == 3'd0) ? 38'sd0 : acc_reg + 38'(prod_reg);
            k_next   = (k_reg == K_LAST) ? 3'd0 : k_reg + 3'd1;
        end

        case (state_reg)
            BS_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    k_next    = 3'd0;
                    n_next[0] = q_item.nx;
                    n_next[1] = q_item.ny;
                    n_next[2] = q_item.nz;
                    s_next[0] = 18'(17'(q_item.px) - 17'(q_item.nx));
                    s_next[1] = 18'(17'(q_item.py) - 17'(q_item.ny));
                    s_next[2] = 18'(17'(q_item.pz) - 17'(q_item.nz));
                    if (q_item.op == OP_STORE)
                    begin
                        if (cnt_reg < CNT_W'(MAX_OBSTACLES))
                        begin
                            tbl_we   = 1'b1;
                            cnt_next = cnt_reg + CNT_W'(1);
                            res_next = ST_STORED;
                        end
                        else
                        begin
                            res_next = ST_FULL;
                        end
                    end
                end
            end
            BS_D2, BS_LEN:
            begin
                mul_a = sk;
                mul_b = sk;
            end
            BS_SQGO:
            begin
                sq_req.start = 1'b1;
                sq_req.val   = acc_reg[SQ_IN_W-1:0];
            end
            BS_SQRT:
            begin
                if (sq_rsp.done)
                begin
                    dist_next = sq_rsp.root;
                    k_next    = 3'd0;
                    if (too_close)
                    begin
                        res_next = ST_CLOSE;
                    end
                end
            end
            BS_SMUL:
            begin
                mul_a = sk;
                mul_b = $signed({3'b0, step_limit});
            end
            BS_SGO:
            begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NUM_W'(prod_mag) + DIV_NUM_W'(dist_reg[16:1]);
                div_req.den   = DIV_DEN_W'(dist_reg);
            end
            BS_SDIV:
            begin
                if (div_rsp.done)
                begin
                    for (int j = 0; j < AXES; j++)
                    begin
                        if (k_reg == 3'(j))
                        begin
                            s_next[j] = s_reg[j][17] ? -$signed(18'(div_rsp.quo))
                                                     : $signed(18'(div_rsp.quo));
                        end
                    end
                    k_next = (k_reg == 3'(AXES - 1)) ? 3'd0 : k_reg + 3'd1;
                end
            end
            BS_LCHK:
            begin
                len_next = acc_reg[33:0];
                idx_next = '0;
                res_next = ST_FREE;
            end
            BS_OC:
            begin
                c_next[0] = 17'(rdata_reg.x) - 17'(n_reg[0]);
                c_next[1] = 17'(rdata_reg.y) - 17'(n_reg[1]);
                c_next[2] = 17'(rdata_reg.z) - 17'(n_reg[2]);
                r_next    = rdata_reg.r;
                k_next    = 3'd0;
            end
            BS_PDOT:
            begin
                mul_a = 18'(ck);
                mul_b = sk;
            end
            BS_PCHK:
            begin
                k_next = 3'd0;
                if (proj_zero)
                begin
                    t_next = '0;
                end
                else if (proj_full)
                begin
                    t_next = T_ONE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = {acc_reg[34:0], 16'b0};
                    div_req.den   = len_reg;
                end
            end
            BS_PDIV:
            begin
                if (div_rsp.done)
                begin
                    t_next = div_rsp.quo;
                end
            end
            BS_QMUL:
            begin
                // product for axis k, rounded offset of axis k-1
                mul_a = $signed({1'b0, t_reg});
                mul_b = sk;
                for (int j = 0; j < AXES; j++)
                begin
                    if (k_reg == 3'(j + 1))
                    begin
                        e_next[j] = 18'(19'(c_reg[j]) - qrnd);
                    end
                end
                k_next = (k_reg == 3'(AXES)) ? 3'd0 : k_reg + 3'd1;
            end
            BS_EDOT:
            begin
                if (k_reg == 3'(AXES))
                begin
                    mul_a = -$signed({3'b0, r_reg});
                    mul_b = $signed({3'b0, r_reg});
                end
                else
                begin
                    mul_a = ek;
                    mul_b = ek;
                end
            end
            BS_ECHK:
            begin
                if (acc_reg <= 38'sd0)
                begin
                    res_next = ST_HIT;
                end
                else if (!last_obst)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            BS_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_reg;
                    if (res_reg == ST_FREE)
                    begin
                        out_x_next = 16'(18'(n_reg[0]) + s_reg[0]);
                        out_y_next = 16'(18'(n_reg[1]) + s_reg[1]);
                        out_z_next = 16'(18'(n_reg[2]) + s_reg[2]);
                    end
                    else
                    begin
                        out_x_next = '0;
                        out_y_next = '0;
                        out_z_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign prod_next = mul_p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            k_reg         <= 3'd0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        n_reg          <= n_next;
        s_reg          <= s_next;
        c_reg          <= c_next;
        e_reg          <= e_next;
        r_reg          <= r_next;
        dist_reg       <= dist_next;
        len_reg        <= len_next;
        t_reg          <= t_next;
        acc_reg        <= acc_next;
        prod_reg       <= prod_next;
        res_reg        <= res_next;
        out_status_reg <= out_status_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_z_reg      <= out_z_next;
    end

    // Obstacle table: one write port, registered read at the walk index
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[cnt_reg[IDX_W-1:0]] <= tbl_wdata;
        end
        rdata_reg <= tbl_mem[idx_reg];
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign new_x     = out_x_reg;
    assign new_y     = out_y_reg;
    assign new_z     = out_z_reg;

endmodule

[sv/rrt_steer_sphere_collision_check_core.sv]
// Top level of the RRT steer and sphere collision core: configuration
// registers, front-end queue, back-end sequencer, divider and square root.
// Depends on rsscc_pkg, rsscc_front, rsscc_back, rsscc_div, rsscc_sqrt.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the step
//   limit (index 0) and the minimum step (index 1); other indexes are
//   ignored. cfg_ready is always high. Write only while the core is idle.
//   in channel carries one request: operation 0 stores a sphere obstacle,
//   operation 1 steers from near_* toward point_* and tests the segment.
//   out channel returns one result per request: status and new_x/y/z.
// Work per request:
//   store: writes the table entry, or reports a full table, then the result.
//   check: squared distance and square root for the distance test, three
//   divisions when the step is clipped, the step length, then per stored obstacle
//   walked a projection division where needed and two dot products on one multiplier.
// One request is worked on at a time; a two-entry queue takes further
// requests meanwhile. The result register lets the next request proceed
// while a result waits; when the receiver stalls with a result held, the
// core stops before loading the next result.
// Reset empties the obstacle table and restores step limit 410, minimum step 1.
module rrt_steer_sphere_collision_check_core
    import rsscc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [14:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_y,
    input  logic signed [15:0] point_z,
    input  logic [14:0]        radius,
    input  logic signed [15:0] near_x,
    input  logic signed [15:0] near_y,
    input  logic signed [15:0] near_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic signed [15:0] new_x,
    output logic signed [15:0] new_y,
    output logic signed [15:0] new_z
);

    logic [14:0] max_step_reg, max_step_next;
    logic [14:0] min_step_reg, min_step_next;
    logic        q_valid;
    item_t       q_item;
    logic        q_pop;
    div_req_t    div_req;
    div_rsp_t    div_rsp;
    sqrt_req_t   sq_req;
    sqrt_rsp_t   sq_rsp;

    assign cfg_ready = 1'b1;

    // Configuration register writes
    always_comb
    begin
        max_step_next = max_step_reg;
        min_step_next = min_step_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAX_STEP: max_step_next = cfg_data;
                CFG_MIN_STEP: min_step_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_step_reg <= MAX_STEP_RST;
            min_step_reg <= MIN_STEP_RST;
        end
        else
        begin
            max_step_reg <= max_step_next;
            min_step_reg <= min_step_next;
        end
    end

    rsscc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .radius    (radius),
        .near_x    (near_x),
        .near_y    (near_y),
        .near_z    (near_z),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    rsscc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_limit (max_step_reg),
        .step_floor (min_step_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .sq_req     (sq_req),
        .sq_rsp     (sq_rsp),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .new_x      (new_x),
        .new_y      (new_y),
        .new_z      (new_z)
    );

    rsscc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    rsscc_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .rsp   (sq_rsp)
    );

endmodule

[sv/rsscc_checker.sv]
// Port-level checks for the collision core, bound to the top level.
// Depends on rsscc_pkg and rrt_steer_sphere_collision_check_core.
module rsscc_checker
    import rsscc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [2:0]         status,
    input logic signed [15:0] new_x,
    input logic signed [15:0] new_y,
    input logic signed [15:0] new_z
);

    // A held result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A held result keeps its status and new_x
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(status) && $stable(new_x))
        else $error("result changed while stalled");

    // Only defined status codes leave the core
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_FULL))
        else $error("undefined status code");

    // Coordinates are zero unless a free point is reported
    a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_FREE) |->
            (new_x == 16'sd0) && (new_y == 16'sd0) && (new_z == 16'sd0))
        else $error("point reported with non-free status");

endmodule

bind rrt_steer_sphere_collision_check_core rsscc_checker u_checker (.*);

[tb/tb_rrt_steer_sphere_collision_check_core.sv]
// Testbench for the RRT steer / sphere collision core: directed and random
// requests checked against a behavioral steer-and-collide predictor.
// Depends on rsscc_pkg and rrt_steer_sphere_collision_check_core.
`timescale 1ns / 100ps

module tb_rrt_steer_sphere_collision_check_core;
    import rsscc_pkg::*;

    localparam int          RAND_PHASE_ITEMS = 265;
    localparam int          HOLD_CYCLES      = 400;
    localparam longint      CYCLE_LIMIT      = 4000000;
    localparam logic [7:0]  CFG_UNUSED       = 8'd7;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [7:0]         cfg_index;
    logic [14:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               operation;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic [14:0]        radius;
    logic signed [15:0] near_x;
    logic signed [15:0] near_y;
    logic signed [15:0] near_z;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         status;
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;
    logic signed [15:0] new_z;

    // Expected result record
    typedef struct {
        status_t            st;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } steer_result_t;

    steer_result_t expected_results[$];

    // Predictor state: obstacle table, count and step registers
    longint obs_x [MAX_OBSTACLES];
    longint obs_y [MAX_OBSTACLES];
    longint obs_z [MAX_OBSTACLES];
    longint obs_r [MAX_OBSTACLES];
    int     obs_count;
    longint step_max;
    longint step_min;

    int     errors;
    bit     idle_en;
    bit     hold_req;
    longint cycles;

    rrt_steer_sphere_collision_check_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .radius    (radius),
        .near_x    (near_x),
        .near_y    (near_y),
        .near_z    (near_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .new_x     (new_x),
        .new_y     (new_y),
        .new_z     (new_z)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Rounded division, ties away from zero; den > 0
    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    // Floor square root, bit by bit
    function automatic longint floor_sqrt(input longint v);
        longint res;
        longint b;
        res = 0;
        b = longint'(1) << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Segment from node (nx,ny,nz) along (sx,sy,sz) against obstacle k
    function automatic bit segment_hits(input int k, input longint nx, input longint ny,
                                        input longint nz, input longint sx,
                                        input longint sy, input longint sz);
        longint cx, cy, cz, len2, dot, t, ex, ey, ez;
        cx = obs_x[k] - nx;
        cy = obs_y[k] - ny;
        cz = obs_z[k] - nz;
        len2 = sx * sx + sy * sy + sz * sz;
        dot = cx * sx + cy * sy + cz * sz;
        if (dot <= 0 || len2 == 0) t = 0;
        else if (dot >= len2) t = 65536;
        else t = (dot * 65536) / len2;
        ex = cx - round_div(t * sx, 65536);
        ey = cy - round_div(t * sy, 65536);
        ez = cz - round_div(t * sz, 65536);
        return (ex * ex + ey * ey + ez * ez) <= obs_r[k] * obs_r[k];
    endfunction

    // Steer and collide prediction for one request; updates the table on store
    function automatic steer_result_t predict_steer(input op_t op,
            input logic signed [15:0] px, input logic signed [15:0] py,
            input logic signed [15:0] pz, input logic [14:0] rad,
            input logic signed [15:0] nx, input logic signed [15:0] ny,
            input logic signed [15:0] nz);
        steer_result_t res;
        longint dx, dy, dz, d2, sx, sy, sz, root_d;
        bit hit;
        res.st = ST_FREE;
        res.x = '0;
        res.y = '0;
        res.z = '0;
        if (op == OP_STORE)
        begin
            if (obs_count < MAX_OBSTACLES)
            begin
                obs_x[obs_count] = px;
                obs_y[obs_count] = py;
                obs_z[obs_count] = pz;
                obs_r[obs_count] = rad;
                obs_count++;
                res.st = ST_STORED;
            end
            else
                res.st = ST_FULL;
            return res;
        end
        dx = longint'(px) - longint'(nx);
        dy = longint'(py) - longint'(ny);
        dz = longint'(pz) - longint'(nz);
        d2 = dx * dx + dy * dy + dz * dz;
        if (d2 < step_min * step_min)
        begin
            res.st = ST_CLOSE;
            return res;
        end
        sx = dx;
        sy = dy;
        sz = dz;
        // clip the extension to the step limit
        if (d2 > step_max * step_max)
        begin
            root_d = floor_sqrt(d2);
            sx = round_div(dx * step_max, root_d);
            sy = round_div(dy * step_max, root_d);
            sz = round_div(dz * step_max, root_d);
        end
        hit = 1'b0;
        for (int k = 0; k < obs_count; k++)
            if (!hit && segment_hits(k, nx, ny, nz, sx, sy, sz)) hit = 1'b1;
        if (hit)
            res.st = ST_HIT;
        else
        begin
            res.x = 16'(longint'(nx) + sx);
            res.y = 16'(longint'(ny) + sy);
            res.z = 16'(longint'(nz) + sz);
        end
        return res;
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        steer_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d x=%0d y=%0d z=%0d",
                         $time, status, new_x, new_y, new_z);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (status !== e.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                    errors++;
                end
                if (new_x !== e.x)
                begin
                    $display("%0t: new_x expected %0d actual %0d", $time, e.x, new_x);
                    errors++;
                end
                if (new_y !== e.y)
                begin
                    $display("%0t: new_y expected %0d actual %0d", $time, e.y, new_y);
                    errors++;
                end
                if (new_z !== e.z)
                begin
                    $display("%0t: new_z expected %0d actual %0d", $time, e.z, new_z);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (idle_en && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Send one request; called at a rising edge
    task automatic send_request(input op_t op, input logic signed [15:0] px,
                                input logic signed [15:0] py, input logic signed [15:0] pz,
                                input logic [14:0] rad, input logic signed [15:0] nx,
                                input logic signed [15:0] ny, input logic signed [15:0] nz);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        point_x   <= px;
        point_y   <= py;
        point_z   <= pz;
        radius    <= rad;
        near_x    <= nx;
        near_y    <= ny;
        near_z    <= nz;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
        expected_results.insert(expected_results.size(),
                                predict_steer(op, px, py, pz, rad, nx, ny, nz));
    endtask

    // Wait until every expected result is in, then let the core settle
    task automatic wait_idle();
        if (in_valid) in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Register write; core must be idle
    task automatic write_reg(input logic [7:0] idx, input logic [14:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        while (!cfg_ready) @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_MAX_STEP) step_max = val;
        else if (idx == CFG_MIN_STEP) step_min = val;
    endtask

    task automatic send_check(input longint px, input longint py, input longint pz,
                              input longint nx, input longint ny, input longint nz);
        send_request(OP_CHECK, 16'(px), 16'(py), 16'(pz), 15'($urandom),
                     16'(nx), 16'(ny), 16'(nz));
    endtask

    task automatic send_store(input longint px, input longint py, input longint pz,
                              input longint rad);
        send_request(OP_STORE, 16'(px), 16'(py), 16'(pz), 15'(rad),
                     16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Defaults: short step passes through, long step is clipped, on-node is too close
    task automatic test_default_steps();
        send_check(300, -200, 100, 0, 0, 0);
        send_check(20000, 5000, -7000, 0, 0, 0);
        send_check(1234, 1234, 1234, 1234, 1234, 1234);
        send_check(-32768, -32768, -32768, 32767, 32767, 32767);
    endtask

    // Obstacle stores at the field extremes, then checks around them
    task automatic test_obstacle_extremes();
        send_store(-32768, -32768, -32768, 0);
        send_store(32767, 32767, 32767, 32767);
        send_store(4000, 0, 0, 800);
        send_check(8000, 0, 0, 3500, 0, 0);
        send_check(4000, 0, 0, 4000, 3000, 0);
        send_check(32767, 32767, 32767, -32768, -32768, -32768);
        send_check(-32768, -32768, -32767, -32768, -32768, -32768);
        send_check(-10000, 0, 0, -10000, 300, 0);
    endtask

    // Zero minimum step, zero step limit, largest steps, ignored register index
    task automatic test_step_extremes();
        write_reg(CFG_MIN_STEP, 15'd0);
        send_check(-5000, 9000, 2000, -5000, 9000, 2000);
        write_reg(CFG_MAX_STEP, 15'd0);
        send_check(12000, -9000, 0, -3000, 2000, 100);
        write_reg(CFG_MAX_STEP, 15'h7FFF);
        write_reg(CFG_MIN_STEP, 15'h7FFF);
        send_check(30000, 0, 0, -30000, 0, 0);
        send_check(100, 0, 0, 0, 0, 0);
        write_reg(CFG_UNUSED, 15'd5);
        send_check(-20000, 20000, 0, 20000, -20000, 0);
        write_reg(CFG_MIN_STEP, 15'd1);
        write_reg(CFG_MAX_STEP, 15'd410);
    endtask

    // Random mix: a few stores, mostly checks in a populated region
    task automatic test_random_mix(input int count);
        longint nx, ny, nz, off;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_request(OP_STORE, 16'($urandom), 16'($urandom), 16'($urandom),
                                 15'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom));
                else
                    send_store($urandom_range(0, 24000) - 12000,
                               $urandom_range(0, 24000) - 12000,
                               $urandom_range(0, 24000) - 12000,
                               $urandom_range(300, 4000));
            end
            else if ($urandom_range(0, 4) == 0)
                send_request(OP_CHECK, 16'($urandom), 16'($urandom), 16'($urandom),
                             15'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom));
            else
            begin
                nx = $urandom_range(0, 24000) - 12000;
                ny = $urandom_range(0, 24000) - 12000;
                nz = $urandom_range(0, 24000) - 12000;
                off = ($urandom_range(0, 2) == 0) ? 600 : 8000;
                send_check(nx + $urandom_range(0, 2 * off) - off,
                           ny + $urandom_range(0, 2 * off) - off,
                           nz + $urandom_range(0, 2 * off) - off, nx, ny, nz);
            end
        end
    endtask

    // Receiver holds off while requests keep coming, filling the queue
    task automatic test_output_stall();
        wait_idle();
        hold_req = 1'b1;
        for (int n = 0; n < 8; n++)
            send_check($urandom_range(0, 2000), 0, 0, 0, $urandom_range(0, 2000), 0);
    endtask

    // Stores past the table size answer table full
    task automatic test_table_full();
        for (int n = 0; n < MAX_OBSTACLES + 2; n++)
            send_store($urandom_range(0, 2000) + 25000, 0, 0, 100);
        send_check(500, 500, 500, 0, 0, 0);
    endtask

    initial
    begin
        cycles    = 0;
        errors    = 0;
        idle_en   = 1'b1;
        hold_req  = 1'b0;
        obs_count = 0;
        step_max  = MAX_STEP_RST;
        step_min  = MIN_STEP_RST;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        operation = OP_STORE;
        point_x   = '0;
        point_y   = '0;
        point_z   = '0;
        radius    = '0;
        near_x    = '0;
        near_y    = '0;
        near_z    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_steps();
        test_obstacle_extremes();
        test_step_extremes();

        test_random_mix(RAND_PHASE_ITEMS);
        write_reg(CFG_MAX_STEP, 15'h7FFF);
        write_reg(CFG_MIN_STEP, 15'd0);
        test_random_mix(RAND_PHASE_ITEMS);
        write_reg(CFG_MAX_STEP, 15'd2000);
        write_reg(CFG_MIN_STEP, 15'd300);
        test_random_mix(RAND_PHASE_ITEMS);
        test_output_stall();

        // last part runs without idling
        wait_idle();
        idle_en = 1'b0;
        write_reg(CFG_MAX_STEP, 15'd1);
        write_reg(CFG_MIN_STEP, 15'd0);
        test_random_mix(RAND_PHASE_ITEMS);
        test_table_full();

        wait_idle();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
